FILE: hdl/tlrg_pkg.sv
// ----------------------------------------------------------------------------
// tlrg_pkg
// Shared types, register codes and helpers of the thin lens ray generator.
// ----------------------------------------------------------------------------
package tlrg_pkg;

  typedef enum logic [2:0] {
    REG_EYE     = 3'd0,
    REG_RIGHT   = 3'd1,
    REG_UP      = 3'd2,
    REG_FORWARD = 3'd3,
    REG_PLANE   = 3'd4,
    REG_LENS    = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [62:0] eye;
    logic [62:0] right;
    logic [62:0] up;
    logic [62:0] forward;
    logic [31:0] plane;
    logic [23:0] lens;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0]       neg;
  } side_t;

  typedef struct packed {
    logic [2:0][29:0] mag;
    side_t            side;
    logic             zero;
  } carry_t;

  function automatic logic signed [20:0] comp(input logic [62:0] v, input int k);
    comp = $signed(v[21*k +: 21]);
  endfunction

endpackage

FILE: hdl/thin_lens_primary_ray_generator.sv
// Throughput: one beat per cycle while the output is not stalled; the
// 32-stage square root and the 17-stage divider are fully pipelined, so
// every stage takes a new item each cycle. A stalled output beat freezes
// the whole pipeline until it is taken. Reset clears all valid bits and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// thin_lens_primary_ray_generator
// Thin lens camera ray generation: origin on the lens, unit direction.
// ----------------------------------------------------------------------------
module thin_lens_primary_ray_generator #(
  parameter int MAX_RESOLUTION = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // column, row, jitter_x, jitter_y, disk_x, disk_y
  input  logic [87:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
  output logic [143:0] m_tdata
);

  tlrg_pkg::cfg_t   cfg;
  logic             en;

  logic             f_valid;
  logic [62:0]      f_mag [3];
  tlrg_pkg::side_t  f_side;
  logic             n_valid;
  logic [61:0]      n_sum;
  tlrg_pkg::carry_t n_carry;
  logic             r_valid;
  logic [30:0]      r_root;
  tlrg_pkg::carry_t r_carry;
  logic [15:0]      dir [3];
  logic [2:0][31:0] origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eye     <= 63'd0;
      cfg.right   <= 63'd1024;
      cfg.up      <= 63'd2147483648;
      cfg.forward <= 63'd225179981368524800;
      cfg.plane   <= 32'd9362;
      cfg.lens    <= 24'd65536;
      cfg.width   <= 13'd640;
      cfg.height  <= 13'd480;
    end else if (cfg_write) begin
      unique case (tlrg_pkg::reg_index_t'(cfg_index))
        tlrg_pkg::REG_EYE:     cfg.eye     <= cfg_data;
        tlrg_pkg::REG_RIGHT:   cfg.right   <= cfg_data;
        tlrg_pkg::REG_UP:      cfg.up      <= cfg_data;
        tlrg_pkg::REG_FORWARD: cfg.forward <= cfg_data;
        tlrg_pkg::REG_PLANE:   cfg.plane   <= cfg_data[31:0];
        tlrg_pkg::REG_LENS:    cfg.lens    <= cfg_data[23:0];
        tlrg_pkg::REG_WIDTH:   cfg.width   <= cfg_data[12:0];
        tlrg_pkg::REG_HEIGHT:  cfg.height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  tlrg_front #(
    .MAX_RESOLUTION(MAX_RESOLUTION)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .column   (s_tdata[11:0]),
    .row      (s_tdata[23:12]),
    .jitter_x (s_tdata[39:24]),
    .jitter_y (s_tdata[55:40]),
    .disk_x   ($signed(s_tdata[71:56])),
    .disk_y   ($signed(s_tdata[87:72])),
    .out_valid(f_valid),
    .out_mag  (f_mag),
    .out_side (f_side)
  );

  tlrg_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .in_mag   (f_mag),
    .in_side  (f_side),
    .out_valid(n_valid),
    .out_sum  (n_sum),
    .out_carry(n_carry)
  );

  tlrg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (n_valid),
    .in_sum   (n_sum),
    .in_carry (n_carry),
    .out_valid(r_valid),
    .out_root (r_root),
    .out_carry(r_carry)
  );

  tlrg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_root   (r_root),
    .in_carry  (r_carry),
    .out_valid (m_tvalid),
    .out_dir   (dir),
    .out_origin(origin)
  );

  assign m_tdata = {dir[2], dir[1], dir[0], origin[2], origin[1], origin[0]};

endmodule

FILE: hdl/tlrg_front.sv
// ----------------------------------------------------------------------------
// tlrg_front
// View-plane and lens points, ray origin and raw direction in five stages.
// ----------------------------------------------------------------------------
module tlrg_front #(
  parameter int MAX_RESOLUTION = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tlrg_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [11:0]         column,
  input  logic [11:0]         row,
  input  logic [15:0]         jitter_x,
  input  logic [15:0]         jitter_y,
  input  logic signed [15:0]  disk_x,
  input  logic signed [15:0]  disk_y,
  output logic                out_valid,
  output logic [62:0]         out_mag [3],
  output tlrg_pkg::side_t     out_side
);

  localparam logic [14:0] RES_LIMIT = 15'(MAX_RESOLUTION);

  logic [12:0]        wres, hres;
  logic signed [30:0] cx_next, cy_next;

  logic               v1, v2, v3, v4, v5;
  logic signed [30:0] cx1, cy1;
  logic signed [40:0] lxp1, lyp1;
  logic signed [63:0] pxp2, pyp2;
  logic signed [25:0] lx2, ly2;
  logic signed [41:0] ax3, ay3;
  logic signed [46:0] ou3 [3];
  logic signed [46:0] ov3 [3];
  logic signed [62:0] du4 [3];
  logic signed [62:0] dv4 [3];
  logic [31:0]        org4 [3];

  logic signed [40:0] lxr, lyr;
  logic signed [63:0] pxr, pyr;
  logic signed [47:0] pxs, pys, dfx, dfy, dfxr, dfyr;
  logic signed [47:0] off_sum [3];
  logic signed [47:0] off_rnd [3];
  logic signed [33:0] org [3];
  logic [31:0]        org_sat [3];
  logic signed [63:0] d_next [3];
  logic signed [63:0] d_neg [3];

  assign wres = ({2'b00, cfg.width} > RES_LIMIT) ? RES_LIMIT[12:0] : cfg.width;
  assign hres = ({2'b00, cfg.height} > RES_LIMIT) ? RES_LIMIT[12:0] : cfg.height;

  assign cx_next = $signed({3'b000, column, 16'h0000}) - $signed({3'b000, wres, 15'h0000})
                   + $signed({15'h0000, jitter_x});
  assign cy_next = $signed({3'b000, row, 16'h0000}) - $signed({3'b000, hres, 15'h0000})
                   + $signed({15'h0000, jitter_y});

  assign lxr  = lxp1 + 41'sd16384;
  assign lyr  = lyp1 + 41'sd16384;
  assign pxr  = pxp2 + 64'sd32768;
  assign pyr  = pyp2 + 64'sd32768;
  assign pxs  = pxr[63:16];
  assign pys  = pyr[63:16];
  assign dfx  = pxs - {{22{lx2[25]}}, lx2};
  assign dfy  = pys - {{22{ly2[25]}}, ly2};
  assign dfxr = dfx + 48'sd32;
  assign dfyr = dfy + 48'sd32;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off_sum[k] = {ou3[k][46], ou3[k]} + {ov3[k][46], ov3[k]};
      off_rnd[k] = off_sum[k] + 48'sd32768;
      org[k]     = {{13{cfg.eye[21*k+20]}}, cfg.eye[21*k +: 21]}
                   + {{2{off_rnd[k][47]}}, off_rnd[k][47:16]};
      if (org[k][33:31] == 3'b000 || org[k][33:31] == 3'b111) begin
        org_sat[k] = org[k][31:0];
      end else if (org[k][33]) begin
        org_sat[k] = 32'h8000_0000;
      end else begin
        org_sat[k] = 32'h7FFF_FFFF;
      end
      d_next[k] = {du4[k][62], du4[k]} + {dv4[k][62], dv4[k]}
                  - {{33{cfg.forward[21*k+20]}}, cfg.forward[21*k +: 21], 10'b0};
      d_neg[k]  = 64'sd0 - d_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx1  <= cx_next;
      cy1  <= cy_next;
      lxp1 <= disk_x * $signed({1'b0, cfg.lens});
      lyp1 <= disk_y * $signed({1'b0, cfg.lens});
      pxp2 <= cx1 * $signed({1'b0, cfg.plane});
      pyp2 <= cy1 * $signed({1'b0, cfg.plane});
      lx2  <= lxr[40:15];
      ly2  <= lyr[40:15];
      ax3  <= dfxr[47:6];
      ay3  <= dfyr[47:6];
      for (int k = 0; k < 3; k++) begin
        ou3[k]             <= lx2 * tlrg_pkg::comp(cfg.right, k);
        ov3[k]             <= ly2 * tlrg_pkg::comp(cfg.up, k);
        du4[k]             <= ax3 * tlrg_pkg::comp(cfg.right, k);
        dv4[k]             <= ay3 * tlrg_pkg::comp(cfg.up, k);
        org4[k]            <= org_sat[k];
        out_mag[k]         <= d_next[k][63] ? d_neg[k][62:0] : d_next[k][62:0];
        out_side.neg[k]    <= d_next[k][63];
        out_side.origin[k] <= org4[k];
      end
    end
  end

  assign out_valid = v5;

endmodule

FILE: hdl/tlrg_norm.sv
// ----------------------------------------------------------------------------
// tlrg_norm
// Leading-one search, common shift of the magnitudes and sum of squares.
// ----------------------------------------------------------------------------
module tlrg_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [62:0]      in_mag [3],
  input  tlrg_pkg::side_t  in_side,
  output logic             out_valid,
  output logic [61:0]      out_sum,
  output tlrg_pkg::carry_t out_carry
);

  logic             v1, v2, v3, v4;
  logic [62:0]      m1 [3];
  logic [62:0]      m2 [3];
  logic [29:0]      m3 [3];
  logic [29:0]      m4 [3];
  logic [59:0]      sq4 [3];
  tlrg_pkg::side_t  s1, s2, s3, s4;
  logic [63:0]      orv1;
  logic [7:0]       grp1;
  logic [5:0]       p2;
  logic             z2, z3, z4;

  logic [63:0]      orv;
  logic [7:0]       grp;
  logic [2:0]       g, b;
  logic [7:0]       byte_sel;
  logic [5:0]       shr;
  logic [62:0]      mval [3];

  assign orv = {1'b0, in_mag[0] | in_mag[1] | in_mag[2]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      grp[i] = |orv[8*i +: 8];
    end
  end

  always_comb begin
    g = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (grp1[i]) g = 3'(i);
    end
    byte_sel = orv1[8*g +: 8];
    b = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (byte_sel[i]) b = 3'(i);
    end
  end

  always_comb begin
    shr = p2 - 6'd29;
    for (int k = 0; k < 3; k++) begin
      if (p2 >= 6'd29) begin
        mval[k] = m2[k] >> shr;
      end else begin
        mval[k] = m2[k] << (6'd29 - p2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orv1 <= orv;
      grp1 <= grp;
      s1   <= in_side;
      p2   <= {g, b};
      z2   <= ~|grp1;
      s2   <= s1;
      z3   <= z2;
      s3   <= s2;
      z4   <= z3;
      s4   <= s3;
      for (int k = 0; k < 3; k++) begin
        m1[k]  <= in_mag[k];
        m2[k]  <= m1[k];
        m3[k]  <= mval[k][29:0];
        m4[k]  <= m3[k];
        sq4[k] <= m3[k] * m3[k];
        out_carry.mag[k] <= m4[k];
      end
      out_sum         <= 62'(sq4[0]) + 62'(sq4[1]) + 62'(sq4[2]);
      out_carry.side  <= s4;
      out_carry.zero  <= z4;
    end
  end

endmodule

FILE: hdl/tlrg_isqrt.sv
// ----------------------------------------------------------------------------
// tlrg_isqrt
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tlrg_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [61:0]      in_sum,
  input  tlrg_pkg::carry_t in_carry,
  output logic             out_valid,
  output logic [30:0]      out_root,
  output tlrg_pkg::carry_t out_carry
);

  localparam int STEPS = 32;

  logic [61:0]      n_s [1:STEPS];
  logic [62:0]      r_s [1:STEPS];
  tlrg_pkg::carry_t c_s [1:STEPS];
  logic             v_s [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * i);
    logic [61:0]      n_in;
    logic [62:0]      r_in;
    tlrg_pkg::carry_t c_in;
    logic             v_in;
    logic [62:0]      trial;
    logic [62:0]      rest;
    logic             take;

    if (i == 0) begin : g_first
      assign n_in = in_sum;
      assign r_in = '0;
      assign c_in = in_carry;
      assign v_in = in_valid;
    end else begin : g_next
      assign n_in = n_s[i];
      assign r_in = r_s[i];
      assign c_in = c_s[i];
      assign v_in = v_s[i];
    end

    assign trial = r_in + BIT;
    assign take  = {1'b0, n_in} >= trial;
    assign rest  = {1'b0, n_in} - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_s[i+1] <= take ? rest[61:0] : n_in;
        r_s[i+1] <= take ? (r_in >> 1) + BIT : r_in >> 1;
        c_s[i+1] <= c_in;
      end
    end
  end

  assign out_valid = v_s[STEPS];
  assign out_root  = r_s[STEPS][30:0];
  assign out_carry = c_s[STEPS];

endmodule

FILE: hdl/tlrg_div.sv
// ----------------------------------------------------------------------------
// tlrg_div
// Three-lane restoring divide by the length, rounding and saturation.
// ----------------------------------------------------------------------------
module tlrg_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [30:0]      in_root,
  input  tlrg_pkg::carry_t in_carry,
  output logic             out_valid,
  output logic [15:0]      out_dir [3],
  output logic [2:0][31:0] out_origin
);

  localparam int QBITS = 17;

  logic [47:0]      rem_s [1:QBITS][3];
  logic [16:0]      q_s   [1:QBITS][3];
  logic [31:0]      d_s   [1:QBITS];
  tlrg_pkg::carry_t c_s   [1:QBITS];
  logic             v_s   [1:QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_bit
    localparam int SH = QBITS - 1 - j;
    logic [47:0]      rem_in [3];
    logic [16:0]      q_in   [3];
    logic [31:0]      d_in;
    tlrg_pkg::carry_t c_in;
    logic             v_in;
    logic [47:0]      sub;
    logic             take [3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = {2'b00, in_carry.mag[k], 16'h0000} + {17'h0, in_root};
          q_in[k]   = '0;
        end
      end
      assign d_in = {in_root, 1'b0};
      assign c_in = in_carry;
      assign v_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_s[j];
      assign q_in   = q_s[j];
      assign d_in   = d_s[j];
      assign c_in   = c_s[j];
      assign v_in   = v_s[j];
    end

    assign sub = {16'h0000, d_in} << SH;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        take[k] = rem_in[k] >= sub;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem_s[j+1][k] <= take[k] ? rem_in[k] - sub : rem_in[k];
          q_s[j+1][k]   <= {q_in[k][15:0], take[k]};
        end
        d_s[j+1] <= d_in;
        c_s[j+1] <= c_in;
      end
    end
  end

  logic [16:0] qs  [3];
  logic [16:0] qn  [3];
  logic [15:0] dir [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k] = (q_s[QBITS][k] > 17'd32768) ? 17'd32768 : q_s[QBITS][k];
      qn[k] = 17'd0 - qs[k];
      if (c_s[QBITS].zero) begin
        dir[k] = 16'h0000;
      end else if (c_s[QBITS].side.neg[k]) begin
        dir[k] = qn[k][15:0];
      end else if (q_s[QBITS][k] > 17'd32767) begin
        dir[k] = 16'h7FFF;
      end else begin
        dir[k] = q_s[QBITS][k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        out_dir[k] <= dir[k];
      end
      out_origin <= c_s[QBITS].side.origin;
    end
  end

endmodule
